// ===== design/ucm_pkg.sv =====
package ucm_pkg;

  typedef logic [20:0] ucm_rune_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } ucm_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       rune_last;
    logic       string_done;
  } ucm_out_t;

  // One step's worth of output: up to four encoded bytes, a bare end marker, or both.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            has_data;
    logic            done;
  } ucm_rec_t;

  function automatic ucm_rune_t ucm_map_upper(input ucm_rune_t r);
    ucm_rune_t m;
    m = r;
    if (r >= 21'h61 && r <= 21'h7A) begin
      m = r - 21'h20;
    end else if ((r >= 21'hE0 && r <= 21'hF6) || (r >= 21'hF8 && r <= 21'hFE)) begin
      m = r - 21'h20;
    end else if (r == 21'hFF) begin
      m = 21'h178;
    end else if (r >= 21'h3B1 && r <= 21'h3C1) begin
      m = r - 21'h20;
    end else if (r == 21'h3C2) begin
      m = 21'h3A3;
    end else if (r >= 21'h3C3 && r <= 21'h3CB) begin
      m = r - 21'h20;
    end else if (r == 21'h3AC) begin
      m = 21'h386;
    end else if (r >= 21'h3AD && r <= 21'h3AF) begin
      m = r - 21'h25;
    end else if (r == 21'h3CC) begin
      m = 21'h38C;
    end else if (r == 21'h3CD || r == 21'h3CE) begin
      m = r - 21'h3F;
    end else if (r >= 21'h430 && r <= 21'h44F) begin
      m = r - 21'h20;
    end else if (r >= 21'h561 && r <= 21'h586) begin
      m = r - 21'h30;
    end else if ((r >= 21'h100 && r <= 21'h12F) || (r >= 21'h14A && r <= 21'h177)) begin
      m = {r[20:1], 1'b0};
    end
    return m;
  endfunction

  function automatic ucm_rune_t ucm_map_lower(input ucm_rune_t r);
    ucm_rune_t m;
    m = r;
    if (r >= 21'h41 && r <= 21'h5A) begin
      m = r + 21'h20;
    end else if ((r >= 21'hC0 && r <= 21'hD6) || (r >= 21'hD8 && r <= 21'hDE)) begin
      m = r + 21'h20;
    end else if (r == 21'h178) begin
      m = 21'hFF;
    end else if ((r >= 21'h391 && r <= 21'h3A1) || (r >= 21'h3A3 && r <= 21'h3AB)) begin
      m = r + 21'h20;
    end else if (r == 21'h386) begin
      m = 21'h3AC;
    end else if (r >= 21'h388 && r <= 21'h38A) begin
      m = r + 21'h25;
    end else if (r == 21'h38C) begin
      m = 21'h3CC;
    end else if (r == 21'h38E || r == 21'h38F) begin
      m = r + 21'h3F;
    end else if (r >= 21'h410 && r <= 21'h42F) begin
      m = r + 21'h20;
    end else if (r >= 21'h531 && r <= 21'h556) begin
      m = r + 21'h30;
    end else if ((r >= 21'h100 && r <= 21'h12F) || (r >= 21'h14A && r <= 21'h177)) begin
      m = {r[20:1], 1'b1};
    end
    return m;
  endfunction

endpackage

// ===== design/ucm_decoder.sv =====
module ucm_decoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              string_end,
  input  logic              mode_upper,
  output logic              emit,
  output ucm_pkg::ucm_rec_t rec
);
  import ucm_pkg::*;

  ucm_rune_t  acc_r, acc_nxt;
  logic [1:0] left_r, left_nxt;
  logic [1:0] len_r, len_nxt;
  logic       stop_r, stop_nxt;
  logic       done;
  ucm_rune_t  mapped;

  always_comb begin
    acc_nxt  = acc_r;
    left_nxt = left_r;
    len_nxt  = len_r;
    stop_nxt = stop_r;
    done     = 1'b0;
    if (!stop_r) begin
      if (left_r == 2'd0) begin
        if (in_byte == 8'h00) begin
          stop_nxt = 1'b1;
        end else if (in_byte < 8'h80) begin
          acc_nxt = {13'd0, in_byte};
          len_nxt = 2'd0;
          done    = 1'b1;
        end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
          acc_nxt  = {16'd0, in_byte[4:0]};
          len_nxt  = 2'd1;
          left_nxt = 2'd1;
        end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
          acc_nxt  = {17'd0, in_byte[3:0]};
          len_nxt  = 2'd2;
          left_nxt = 2'd2;
        end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
          acc_nxt  = {18'd0, in_byte[2:0]};
          len_nxt  = 2'd3;
          left_nxt = 2'd3;
        end else begin
          stop_nxt = 1'b1;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        stop_nxt = 1'b1;
        left_nxt = 2'd0;
      end else begin
        acc_nxt  = {acc_r[14:0], in_byte[5:0]};
        left_nxt = left_r - 2'd1;
        if (left_r == 2'd1) begin
          // Overlong, surrogate and out-of-range forms drop the rune and halt decoding until the string ends.
          if (len_r == 2'd2) begin
            done = (acc_nxt >= 21'h800) && (acc_nxt < 21'hD800 || acc_nxt > 21'hDFFF);
          end else if (len_r == 2'd3) begin
            done = (acc_nxt >= 21'h10000) && (acc_nxt <= 21'h10FFFF);
          end else begin
            done = 1'b1;
          end
          stop_nxt = !done;
        end
      end
    end

    mapped = mode_upper ? ucm_map_upper(acc_nxt) : ucm_map_lower(acc_nxt);

    rec          = '0;
    rec.has_data = done;
    rec.done     = string_end;
    if (done) begin
      rec.last_idx = len_nxt;
      unique case (len_nxt)
        2'd0: begin
          rec.bytes[0] = {1'b0, mapped[6:0]};
        end
        2'd1: begin
          rec.bytes[0] = {3'b110, mapped[10:6]};
          rec.bytes[1] = {2'b10, mapped[5:0]};
        end
        2'd2: begin
          rec.bytes[0] = {4'b1110, mapped[15:12]};
          rec.bytes[1] = {2'b10, mapped[11:6]};
          rec.bytes[2] = {2'b10, mapped[5:0]};
        end
        2'd3: begin
          rec.bytes[0] = {5'b11110, mapped[20:18]};
          rec.bytes[1] = {2'b10, mapped[17:12]};
          rec.bytes[2] = {2'b10, mapped[11:6]};
          rec.bytes[3] = {2'b10, mapped[5:0]};
        end
        default: begin
          rec.bytes = '0;
        end
      endcase
    end
    emit = done || string_end;

    if (string_end) begin
      acc_nxt  = '0;
      left_nxt = 2'd0;
      len_nxt  = 2'd0;
      stop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      left_r <= 2'd0;
      len_r  <= 2'd0;
      stop_r <= 1'b0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      left_r <= left_nxt;
      len_r  <= len_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ===== design/utf8_case_mapper.sv =====
// Channel  Direction  Payload      Handshake
// in_      input      ucm_in_t     in_valid / in_ready
// out_     output     ucm_out_t    out_valid / out_ready
// cfg_     input      mode_upper   cfg_wr_en, no wait
//
// A request enters the input register, is decoded and case-mapped from there and lands
// in the result register, which presents one byte per cycle while out_ready is high.
// One request a cycle is sustained while out_ready is high; a rune of n bytes holds
// the result register until all are taken, overlapping the following rune's lead bytes.
// Reset is synchronous and clears the rune state, both valid flags and selects upper case.
// A stall on out_ready backs up into in_ready once the request waiting in the input
// register needs the result register.
module utf8_case_mapper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ucm_pkg::ucm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ucm_pkg::ucm_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data
);
  import ucm_pkg::*;

  logic       mode_r;
  logic       inq_vld_r;
  ucm_in_t    inq_r;
  logic       rec_vld_r;
  ucm_rec_t   rec_r;
  logic [1:0] idx_r;

  logic       emit;
  ucm_rec_t   rec_new;
  logic       out_fire;
  logic       rec_last_take;
  logic       step;

  ucm_decoder u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .in_byte    (inq_r.in_byte),
    .string_end (inq_r.string_end),
    .mode_upper (mode_r),
    .emit       (emit),
    .rec        (rec_new)
  );

  always_comb begin
    out_fire      = out_valid && out_ready;
    rec_last_take = out_fire && (idx_r == rec_r.last_idx);
    step          = inq_vld_r && (!emit || !rec_vld_r || rec_last_take);
    in_ready      = !inq_vld_r || step;

    out_valid            = rec_vld_r;
    out_data.out_byte    = rec_r.has_data ? rec_r.bytes[idx_r] : 8'h00;
    out_data.byte_valid  = rec_r.has_data;
    out_data.rune_last   = (idx_r == rec_r.last_idx);
    out_data.string_done = rec_r.done && (idx_r == rec_r.last_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_vld_r <= 1'b0;
    end else if (in_ready) begin
      inq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (step && emit) begin
      rec_vld_r <= 1'b1;
      idx_r     <= 2'd0;
    end else if (rec_last_take) begin
      rec_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (out_fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rec_r <= rec_new;
    end
  end

endmodule

// ===== design/ucm_checker.sv =====
module ucm_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input ucm_pkg::ucm_out_t out_data
);
  import ucm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_valid |->
      out_data.rune_last && out_data.string_done && out_data.out_byte == 8'h00)
    else $error("bare end marker malformed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_done |-> out_data.rune_last)
    else $error("string closed before the last byte of a request");

  a_cont_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.rune_last |=>
      out_valid && out_data.byte_valid && out_data.out_byte[7:6] == 2'b10)
    else $error("continuation byte missing inside a rune");

endmodule

bind utf8_case_mapper ucm_checker u_ucm_checker (.*);
